// ===== hdl/btlu_pkg.sv =====
// Shared types, codes and record decoding for the binary trie prefix lookup unit.
// Used by hdl/binary_trie_ip_prefix_lookup_unit.sv; depends on nothing else.

package btlu_pkg;

	// Default depth of the node memory.
	localparam int DEF_MAX_NODES = 4096;

	// Address widths walked for the two address families.
	localparam int IPV4_BITS = 32;
	localparam int IPV6_BITS = 128;

	// Pointers below this bias are reserved and rejected.
	localparam logic [31:0] PTR_BIAS = 32'd16;

	// Transaction kinds.
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_NODE_COUNT  = 3'd0,
		CFG_RECORD_MODE = 3'd1,
		CFG_DB_IS_V6    = 3'd2,
		CFG_V4_START    = 3'd3,
		CFG_DATA_SIZE   = 3'd4
	} cfg_idx_t;

	// Record size modes.
	typedef enum logic [1:0] {
		REC_24 = 2'd0,
		REC_28 = 2'd1,
		REC_32 = 2'd2
	} rec_mode_t;

	// Lookup result codes.
	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NO_DATA   = 3'd1,
		ST_V6_IN_V4  = 3'd2,
		ST_LOW_PTR   = 3'd3,
		ST_BOUNDS    = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_CHECK,
		S_FINAL
	} state_t;

	// Pulls the left (side 0) or right (side 1) record out of a packed node.
	// The unused mode returns the node count, which ends any walk with no data.
	function automatic logic [31:0] rec_extract(
		input logic [63:0] p,
		input logic        side,
		input logic [1:0]  mode,
		input logic [12:0] nc
	);
		logic [31:0] r;
		unique case (mode)
			REC_24: begin
				r = side ? {8'd0, p[39:16]} : {8'd0, p[63:40]};
			end
			REC_28: begin
				r = side ? {4'd0, p[35:32], p[31:8]} : {4'd0, p[39:36], p[63:40]};
			end
			REC_32: begin
				r = side ? p[31:0] : p[63:32];
			end
			default: begin
				r = {19'd0, nc};
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/binary_trie_ip_prefix_lookup_unit.sv =====
// Top level of the binary trie IP longest-prefix lookup unit: node memory,
// walk sequencer and final offset check. Depends on hdl/btlu_pkg.sv.

// A transaction is taken when start is high and busy is low. A node write
// (kind 0) is stored at that edge and the unit stays free, so a new transaction
// may follow in the very next cycle. A lookup (kind 1) walks the tree one
// address bit per clock, because each step needs one read of the node memory
// whose result chooses the next address. While a lookup reads its k nodes and
// then decodes the last record, forms the pointer and runs the bounds checks,
// busy stays high. k is at most 32 for IPv4 and 128 for IPv6. An IPv6 address
// given to an IPv4-only database is answered at once, in the cycle after it is
// taken, without busy going high. Every lookup gives exactly one result, shown
// on status and data_offset for a single cycle with done high; the receiver
// cannot hold it off, so it must capture it in that cycle. The node memory is
// not cleared by reset: every node a walk can reach must be written first.
// Configuration registers must be written only while the unit is idle and no
// result is still due.

module binary_trie_ip_prefix_lookup_unit #(
	parameter int MAX_NODES = btlu_pkg::DEF_MAX_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	// Transaction port.
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [11:0] node_index,
	input  logic [63:0] node_bytes,
	input  logic        is_ipv4,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	// Result port.
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] data_offset,
	// Configuration port.
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam logic [31:0] NODE_LIMIT = 32'(MAX_NODES);

	// Configuration registers.
	logic [12:0] num_nodes_q;
	logic [1:0]  rec_mode_q;
	logic        db_v6_q;
	logic [31:0] v4_start_q;
	logic [31:0] data_size_q;

	// Sequencer and walk state.
	btlu_pkg::state_t state_q, state_nxt;
	logic        pend_q;
	logic [7:0]  bits_left_q;
	logic [31:0] node_q;
	logic [127:0] addr_q;
	logic        side_q;
	logic        in_range_q;
	logic [63:0] rd_data_q;
	logic [31:0] ptr_q;
	logic        nodata_q;

	// Result registers.
	logic        done_q;
	btlu_pkg::status_t status_q;
	logic [31:0] offset_q;

	// The node memory itself.
	logic [63:0] node_mem [MAX_NODES];

	// Combinational control.
	logic        accept;
	logic        acc_lookup;
	logic        acc_write;
	logic        acc_reject;
	logic        mem_we;
	logic        mem_re;
	logic [31:0] walk_node;
	logic        walk_more;
	logic [31:0] nc_ext;
	logic [31:0] off_calc;

	assign nc_ext     = {19'd0, num_nodes_q};
	assign accept     = start && (state_q == btlu_pkg::S_IDLE);
	assign acc_write  = accept && (kind == btlu_pkg::KIND_WRITE);
	assign acc_lookup = accept && (kind == btlu_pkg::KIND_LOOKUP) && (is_ipv4 || db_v6_q);
	// An IPv6 address against an IPv4-only tree is refused without a walk.
	assign acc_reject = accept && (kind == btlu_pkg::KIND_LOOKUP) && !is_ipv4 && !db_v6_q;

	// The shared step unit: decode the record that the last read returned, or
	// hold the start node before the first read. A node beyond the memory reads
	// as all zero bytes.
	assign walk_node = pend_q
		? btlu_pkg::rec_extract(in_range_q ? rd_data_q : 64'd0, side_q, rec_mode_q,
			num_nodes_q)
		: node_q;
	assign walk_more = (walk_node < nc_ext) && (bits_left_q != 8'd0);

	assign off_calc = ptr_q - btlu_pkg::PTR_BIAS;

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			btlu_pkg::S_IDLE: begin
				if (acc_lookup) begin
					state_nxt = btlu_pkg::S_WALK;
				end
			end
			btlu_pkg::S_WALK: begin
				if (!walk_more) begin
					state_nxt = btlu_pkg::S_CHECK;
				end
			end
			btlu_pkg::S_CHECK: begin
				state_nxt = btlu_pkg::S_FINAL;
			end
			btlu_pkg::S_FINAL: begin
				state_nxt = btlu_pkg::S_IDLE;
			end
			default: begin
				state_nxt = btlu_pkg::S_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer: memory strobes.
	always_comb begin
		mem_we = acc_write && ({20'd0, node_index} < NODE_LIMIT);
		mem_re = (state_q == btlu_pkg::S_WALK) && walk_more;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_nodes_q <= 13'd1;
			rec_mode_q  <= 2'd0;
			db_v6_q     <= 1'b0;
			v4_start_q  <= 32'd0;
			data_size_q <= 32'd0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				btlu_pkg::CFG_NODE_COUNT:  num_nodes_q <= cfg_data[12:0];
				btlu_pkg::CFG_RECORD_MODE: rec_mode_q  <= cfg_data[1:0];
				btlu_pkg::CFG_DB_IS_V6:    db_v6_q     <= cfg_data[0];
				btlu_pkg::CFG_V4_START:    v4_start_q  <= cfg_data;
				btlu_pkg::CFG_DATA_SIZE:   data_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btlu_pkg::S_IDLE;
			pend_q      <= 1'b0;
			bits_left_q <= 8'd0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= acc_reject || (state_q == btlu_pkg::S_FINAL);
			if (acc_lookup) begin
				pend_q      <= 1'b0;
				bits_left_q <= is_ipv4 ? 8'(btlu_pkg::IPV4_BITS) : 8'(btlu_pkg::IPV6_BITS);
			end else if (state_q == btlu_pkg::S_WALK) begin
				pend_q <= mem_re;
				if (mem_re) begin
					bits_left_q <= bits_left_q - 8'd1;
				end
			end
		end
	end

	// Walk datapath and result registers.
	always_ff @(posedge clk) begin
		if (acc_lookup) begin
			node_q <= (is_ipv4 && db_v6_q) ? v4_start_q : 32'd0;
			addr_q <= is_ipv4 ? {addr_low[31:0], 96'd0} : {addr_high, addr_low};
		end else if (state_q == btlu_pkg::S_WALK) begin
			node_q <= walk_node;
			if (mem_re) begin
				addr_q     <= {addr_q[126:0], 1'b0};
				side_q     <= addr_q[127];
				in_range_q <= walk_node < NODE_LIMIT;
			end
		end
		if (state_q == btlu_pkg::S_CHECK) begin
			ptr_q    <= node_q - nc_ext;
			nodata_q <= node_q <= nc_ext;
		end
		if (acc_reject) begin
			status_q <= btlu_pkg::ST_V6_IN_V4;
			offset_q <= 32'd0;
		end else if (state_q == btlu_pkg::S_FINAL) begin
			if (nodata_q) begin
				status_q <= btlu_pkg::ST_NO_DATA;
				offset_q <= 32'd0;
			end else if (ptr_q < btlu_pkg::PTR_BIAS) begin
				status_q <= btlu_pkg::ST_LOW_PTR;
				offset_q <= 32'd0;
			end else if (off_calc >= data_size_q) begin
				status_q <= btlu_pkg::ST_BOUNDS;
				offset_q <= 32'd0;
			end else begin
				status_q <= btlu_pkg::ST_FOUND;
				offset_q <= off_calc;
			end
		end
	end

	// Node memory: one write port for node loads, one registered read port
	// for the walk. The two are never active in the same cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[AW'(node_index)] <= node_bytes;
		end
		if (mem_re) begin
			rd_data_q <= node_mem[AW'(walk_node)];
		end
	end

	assign busy        = (state_q != btlu_pkg::S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign data_offset = offset_q;

	// A result appears only after the final check or an immediate refusal.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == btlu_pkg::S_FINAL) || $past(acc_reject))
		else $error("result strobe without a finished lookup");

	// A failed lookup never reports an offset.
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != btlu_pkg::ST_FOUND)) |-> (offset_q == 32'd0))
		else $error("nonzero offset with a failure status");

	// The bit budget never exceeds the IPv6 address width.
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= 8'(btlu_pkg::IPV6_BITS))
		else $error("bit counter beyond address width");

	// The unit only becomes busy after taking a lookup transaction.
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && (kind == btlu_pkg::KIND_LOOKUP)))
		else $error("busy without an accepted lookup");

	// A memory read is issued only while bits remain to be walked.
	a_read_budget: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (bits_left_q < 8'(btlu_pkg::IPV6_BITS)) && pend_q)
		else $error("walk read outside the bit budget");

endmodule

// ===== test/binary_trie_ip_prefix_lookup_unit_tb.sv =====
// Self-checking testbench for the binary trie IP longest-prefix lookup unit.
// Depends on hdl/btlu_pkg.sv and hdl/binary_trie_ip_prefix_lookup_unit.sv.

module binary_trie_ip_prefix_lookup_unit_tb;

	// A cycle counts as quiet when no transaction, result or register write
	// is taken. The longest legal quiet stretch is the final drain, a little
	// longer than one IPv6 walk plus an idle burst, so this limit leaves a
	// wide margin.
	localparam int QUIET_LIMIT = 1000;
	localparam int STORE_DEPTH = btlu_pkg::DEF_MAX_NODES;

	// One expected lookup answer.
	typedef struct packed {
		btlu_pkg::status_t st;
		logic [31:0]       offset;
	} lookup_answer_t;

	// Keeps its own copy of the node memory and the registers, works out the
	// answer of every accepted lookup and compares the answers the unit gives.
	class trie_lookup_checker;
		bit [63:0]      node_mem [STORE_DEPTH];
		logic [31:0]    num_nodes;
		logic [1:0]     rec_mode;
		logic           db_v6;
		logic [31:0]    ipv4_start;
		logic [31:0]    data_size;
		lookup_answer_t pending_answers [$];
		int             errors;

		function new();
			num_nodes = 32'd1;
			rec_mode = btlu_pkg::REC_24;
			db_v6 = 1'b0;
			ipv4_start = 32'd0;
			data_size = 32'd0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				btlu_pkg::CFG_NODE_COUNT: num_nodes = {19'd0, val[12:0]};
				btlu_pkg::CFG_RECORD_MODE: rec_mode = val[1:0];
				btlu_pkg::CFG_DB_IS_V6: db_v6 = val[0];
				btlu_pkg::CFG_V4_START: ipv4_start = val;
				btlu_pkg::CFG_DATA_SIZE: data_size = val;
				default: ;
			endcase
		endfunction

		// Record that the given address bit selects in a node. Nodes past the
		// end of the store read as all zero bytes.
		function logic [31:0] record_of(logic [31:0] node, logic side);
			logic [63:0] p;
			logic [7:0]  b [8];
			p = (node < STORE_DEPTH) ? node_mem[node[11:0]] : 64'd0;
			for (int i = 0; i < 8; i++)
				b[i] = p[63 - 8 * i -: 8];
			case (rec_mode)
				btlu_pkg::REC_24: return side ? {8'd0, b[3], b[4], b[5]}
						: {8'd0, b[0], b[1], b[2]};
				btlu_pkg::REC_28: return side ? {4'd0, b[3][3:0], b[4], b[5], b[6]}
						: {4'd0, b[3][7:4], b[0], b[1], b[2]};
				btlu_pkg::REC_32: return side ? {b[4], b[5], b[6], b[7]}
						: {b[0], b[1], b[2], b[3]};
				default: return num_nodes;
			endcase
		endfunction

		function lookup_answer_t resolve_lookup(logic v4, logic [63:0] ah, logic [63:0] al);
			logic [127:0]   full_addr;
			logic [31:0]    node;
			logic [31:0]    ptr;
			lookup_answer_t ans;
			full_addr = {ah, al};
			ans.st = btlu_pkg::ST_FOUND;
			ans.offset = 32'd0;
			if (v4) begin
				node = db_v6 ? ipv4_start : 32'd0;
				for (int b = 0; b < btlu_pkg::IPV4_BITS && node < num_nodes; b++)
					node = record_of(node, al[31 - b]);
			end else if (!db_v6) begin
				ans.st = btlu_pkg::ST_V6_IN_V4;
				return ans;
			end else begin
				node = 32'd0;
				for (int b = 0; b < btlu_pkg::IPV6_BITS && node < num_nodes; b++)
					node = record_of(node, full_addr[127 - b]);
			end
			if (node <= num_nodes) begin
				ans.st = btlu_pkg::ST_NO_DATA;
			end else begin
				ptr = node - num_nodes;
				if (ptr < btlu_pkg::PTR_BIAS)
					ans.st = btlu_pkg::ST_LOW_PTR;
				else if (ptr - btlu_pkg::PTR_BIAS >= data_size)
					ans.st = btlu_pkg::ST_BOUNDS;
				else
					ans.offset = ptr - btlu_pkg::PTR_BIAS;
			end
			return ans;
		endfunction

		function void note_transaction(logic k, logic [11:0] idx, logic [63:0] nb, logic v4,
				logic [63:0] ah, logic [63:0] al);
			if (k == btlu_pkg::KIND_WRITE)
				node_mem[idx] = nb;
			else
				pending_answers.insert(pending_answers.size(), resolve_lookup(v4, ah, al));
		endfunction

		function void check_answer(logic [2:0] st, logic [31:0] off);
			lookup_answer_t want;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result: expected none, got status %0d offset %0d",
					$time, st, off);
				errors++;
				return;
			end
			want = pending_answers.pop_front();
			if (st !== want.st) begin
				$display("%0t: status mismatch: expected %0d, got %0d", $time, want.st, st);
				errors++;
			end
			if (off !== want.offset) begin
				$display("%0t: data_offset mismatch: expected %0d, got %0d",
					$time, want.offset, off);
				errors++;
			end
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = btlu_pkg::KIND_WRITE;
	logic [11:0] node_index = 12'd0;
	logic [63:0] node_bytes = 64'd0;
	logic        is_ipv4 = 1'b0;
	logic [63:0] addr_high = 64'd0;
	logic [63:0] addr_low = 64'd0;
	logic        done;
	logic [2:0]  status;
	logic [31:0] data_offset;
	logic        cfg_write_en = 1'b0;
	logic [2:0]  cfg_index = btlu_pkg::CFG_NODE_COUNT;
	logic [31:0] cfg_data = 32'd0;

	trie_lookup_checker sb = new();
	int quiet_cycles = 0;
	int items_sent = 0;

	// Settings of the current phase, used to build trees that the walks can
	// only leave through written nodes or terminal records.
	logic [31:0]  cur_nc;
	logic [1:0]   cur_mode;
	logic         cur_v6;
	logic [31:0]  cur_dsize;
	int unsigned  tree_nodes [$];
	int           child_pct;

	binary_trie_ip_prefix_lookup_unit u_dut (
		.clk, .arst_n,
		.start, .busy, .kind, .node_index, .node_bytes, .is_ipv4, .addr_high, .addr_low,
		.done, .status, .data_offset,
		.cfg_write_en, .cfg_index, .cfg_data
	);

	always #4 clk = ~clk;

	// Monitor: everything is sampled at the rising edge, before the nonblocking
	// updates of that edge land, so the values seen are the ones the unit saw.
	// A lookup taken at this edge is queued behind any answer that shows up at
	// the same edge, which always belongs to an earlier lookup.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write_en)
				sb.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_transaction(kind, node_index, node_bytes, is_ipv4,
					addr_high, addr_low);
			if (done)
				sb.check_answer(status, data_offset);
			if ((start && !busy) || done || cfg_write_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Packs a left and a right record into node bytes for the current record
	// width. The unused mode ignores node contents, so it gets random bytes.
	function automatic logic [63:0] pack_node(logic [31:0] l, logic [31:0] r);
		case (cur_mode)
			btlu_pkg::REC_24: return {l[23:0], r[23:0], 16'h0};
			btlu_pkg::REC_28: return {l[23:0], l[27:24], r[27:24], r[23:0], 8'h0};
			btlu_pkg::REC_32: return {l, r};
			default: return rand64();
		endcase
	endfunction

	// Either a link to a node of the current tree, or a terminal record aimed
	// at one of the outcomes of the offset check, with the bounds edges hit
	// on purpose. Everything is clamped to what the record width can hold.
	function automatic logic [31:0] pick_record();
		longint unsigned rmax, v, lim;
		if ($urandom_range(1, 100) <= child_pct)
			return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
		case (cur_mode)
			btlu_pkg::REC_24: rmax = 64'hFF_FFFF;
			btlu_pkg::REC_28: rmax = 64'hFFF_FFFF;
			default: rmax = 64'hFFFF_FFFF;
		endcase
		case ($urandom_range(0, 4))
			0: v = cur_nc;
			1: v = cur_nc + $urandom_range(1, 15);
			2: begin
				lim = cur_dsize;
				if (rmax - cur_nc - 15 < lim)
					lim = rmax - cur_nc - 15;
				v = cur_nc + 16 + ((lim == 0) ? 0 : ({$urandom} % lim));
			end
			3: v = cur_nc + 15 + cur_dsize + $urandom_range(0, 2);
			default: begin
				v = $urandom & rmax;
				if (v < cur_nc)
					v = rmax;
			end
		endcase
		if (v > rmax)
			v = rmax;
		return v[31:0];
	endfunction

	function automatic logic [63:0] fresh_node();
		logic [31:0] l, r;
		l = pick_record();
		r = pick_record();
		return pack_node(l, r);
	endfunction

	// Presents one transaction and returns at the edge that takes it. The
	// caller then either presents the next one or lowers start, so start never
	// gets two assignments in one step.
	task automatic send_item(input logic k, input logic [11:0] idx, input logic [63:0] nb,
			input logic v4, input logic [63:0] ah, input logic [63:0] al);
		start <= 1'b1;
		kind <= k;
		node_index <= idx;
		node_bytes <= nb;
		is_ipv4 <= v4;
		addr_high <= ah;
		addr_low <= al;
		items_sent++;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Fields that a transaction ignores still carry random values.
	task automatic write_node(input logic [11:0] idx, input logic [63:0] nb);
		send_item(btlu_pkg::KIND_WRITE, idx, nb, 1'($urandom), rand64(), rand64());
	endtask

	task automatic lookup(input logic v4, input logic [63:0] ah, input logic [63:0] al);
		send_item(btlu_pkg::KIND_LOOKUP, 12'($urandom), rand64(), v4, ah, al);
	endtask

	// Stops sending until every lookup has been answered and the unit is free,
	// then leaves a few cycles for a node write that was just taken.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all five registers back to back while the unit is idle.
	task automatic set_config(input logic [31:0] nc, input logic [1:0] md, input logic v6,
			input logic [31:0] v4s, input logic [31:0] ds);
		settle();
		cur_nc = nc;
		cur_mode = md;
		cur_v6 = v6;
		cur_dsize = ds;
		cfg_write_en <= 1'b1;
		cfg_index <= btlu_pkg::CFG_NODE_COUNT;
		cfg_data <= nc;
		@(posedge clk);
		cfg_index <= btlu_pkg::CFG_RECORD_MODE;
		cfg_data <= {30'd0, md};
		@(posedge clk);
		cfg_index <= btlu_pkg::CFG_DB_IS_V6;
		cfg_data <= {31'd0, v6};
		@(posedge clk);
		cfg_index <= btlu_pkg::CFG_V4_START;
		cfg_data <= v4s;
		@(posedge clk);
		cfg_index <= btlu_pkg::CFG_DATA_SIZE;
		cfg_data <= ds;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          n, wsize, idle_pct;
		logic [31:0] nc, v4s, ds;
		logic [1:0]  md;
		logic        v6, v4;
		logic [63:0] ah, al;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A small 24-bit IPv4 tree whose leaves cover no data,
		// a pointer below the bias, the first and last offsets in bounds and
		// the first one out of bounds, plus an IPv6 address in an IPv4 tree.
		set_config(32'd4, btlu_pkg::REC_24, 1'b0, 32'd0, 32'd100);
		write_node(12'd0, pack_node(32'd1, 32'd2));
		write_node(12'd1, pack_node(32'd4, 32'd9));
		write_node(12'd2, pack_node(32'd20, 32'd3));
		write_node(12'd3, pack_node(32'd119, 32'd120));
		lookup(1'b1, rand64(), {$urandom, 32'h0000_0000});
		lookup(1'b1, rand64(), {$urandom, 32'h4000_0000});
		lookup(1'b1, rand64(), {$urandom, 32'h8000_0000});
		lookup(1'b1, rand64(), {$urandom, 32'hC000_0000});
		lookup(1'b1, rand64(), {$urandom, 32'hE000_0000});
		lookup(1'b1, '1, '1);
		lookup(1'b0, rand64(), rand64());

		// Full 32-bit records and the largest node count. Self loops make the
		// walks run out of address bits: 128 steps for IPv6 and 32 steps from
		// the IPv4 start node. The all-ones record is the largest offset.
		set_config(32'd4096, btlu_pkg::REC_32, 1'b1, 32'd7, 32'hFFFF_FFFF);
		write_node(12'd0, pack_node(32'd0, 32'hFFFF_FFFF));
		write_node(12'd7, pack_node(32'd7, 32'd7));
		lookup(1'b0, 64'd0, 64'd0);
		lookup(1'b0, 64'd0, 64'd1);
		lookup(1'b0, '1, rand64());
		lookup(1'b1, rand64(), rand64());

		// Zero node count: no step is taken and the start node itself is the
		// final record.
		set_config(32'd0, btlu_pkg::REC_28, 1'b1, 32'hFFFF_FFFF, 32'd0);
		lookup(1'b1, rand64(), rand64());
		lookup(1'b0, rand64(), rand64());

		// The unused record mode reads every record as the node count.
		set_config(32'd5, 2'd3, 1'b1, 32'd0, 32'd0);
		lookup(1'b1, rand64(), rand64());
		lookup(1'b0, rand64(), rand64());

		// A node count past the end of the store: node 5000 reads as zeros
		// and leads back to node 0.
		set_config(32'd8191, btlu_pkg::REC_24, 1'b0, 32'd0, 32'hFFFF_FFFF);
		write_node(12'd0, pack_node(32'd5000, 32'hFF_FFFF));
		lookup(1'b1, rand64(), {$urandom, 32'h0000_0001});
		lookup(1'b1, rand64(), {$urandom, 32'h8000_0000});
		lookup(1'b1, rand64(), {$urandom, 32'h5555_5555});

		// Random phases. Each one picks settings, builds a small tree with
		// cycles inside the node count and writes it, then mixes lookups with
		// occasional rewrites of tree nodes. Every record points either into
		// the tree or at a terminal value, so no walk reads an unwritten node.
		while (items_sent < 950) begin
			case ($urandom_range(0, 5))
				0: nc = 32'd1;
				1: nc = 32'd2;
				2: nc = 32'd4096;
				5: nc = $urandom_range(65, 4096);
				default: nc = $urandom_range(3, 64);
			endcase
			md = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			v6 = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: ds = 32'd0;
				1: ds = 32'hFFFF_FFFF;
				2: ds = $urandom_range(1, 64);
				default: ds = $urandom;
			endcase
			tree_nodes.delete();
			tree_nodes.insert(tree_nodes.size(), 0);
			wsize = $urandom_range(4, 48);
			for (int i = 1; i < wsize && nc > 1; i++)
				tree_nodes.insert(tree_nodes.size(), $urandom_range(1, nc - 1));
			case ($urandom_range(0, 4))
				0: v4s = nc;
				1: begin
					v4s = $urandom;
					if (v4s < nc)
						v4s = nc + 16;
				end
				default: v4s = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
			endcase
			case ($urandom_range(0, 2))
				0: child_pct = 60;
				1: child_pct = 85;
				default: child_pct = 97;
			endcase
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 20;
				default: idle_pct = 50;
			endcase

			set_config(nc, md, v6, v4s, ds);
			foreach (tree_nodes[i])
				write_node(12'(tree_nodes[i]), fresh_node());

			n = $urandom_range(50, 90);
			for (int i = 0; i < n; i++) begin
				// The tail of the run keeps the sender busy every cycle.
				if (items_sent < 820 && $urandom_range(1, 100) <= idle_pct) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				if (items_sent < 820 && $urandom_range(1, 50) == 1)
					settle();
				if ($urandom_range(1, 10) == 1) begin
					write_node(12'(tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]),
						fresh_node());
				end else begin
					v4 = cur_v6 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
					case ($urandom_range(0, 9))
						0: begin
							ah = 64'd0;
							al = 64'd0;
						end
						1: begin
							ah = '1;
							al = '1;
						end
						default: begin
							ah = rand64();
							al = rand64();
						end
					endcase
					lookup(v4, ah, al);
				end
			end
		end

		// Drain: wait for the last answers, then leave room for a stray one.
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== binary_trie_ip_prefix_lookup_unit.f =====
hdl/btlu_pkg.sv
hdl/binary_trie_ip_prefix_lookup_unit.sv
test/binary_trie_ip_prefix_lookup_unit_tb.sv
